// ===== rtl/obm_pkg.sv =====
// Package: shared types and codes for the order book matcher.
`default_nettype none
package obm_pkg;
	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_LOAD   = 2'd1,
		ACT_MARKET = 2'd2,
		ACT_LIMIT  = 2'd3
	} action_t;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_SHIFT  = 5'b00100,
		ST_TAKE   = 5'b01000,
		ST_POP    = 5'b10000
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/order_book_matcher_unit.sv =====
// Top level: price-time priority order book with iterative load and match sequencer.
//
//  channel  | direction | handshake            | words
//  ---------+-----------+----------------------+------------------------------
//  command  | in        | start & !busy        | action, order_side, price, qty
//  result   | out       | valid (one cycle)    | is_fill, fill_*, unfilled, ...
//
// Sequencing: a clear empties both sides and gives the summary. A load scans
// the book one entry a cycle to find its place, then shifts the tail one entry
// a cycle. A market or limit order uses one shared compare and subtract unit:
// each fill that leaves a remainder leads straight to the next take, each fill
// that empties the best order to a pop that shifts the book; then the summary.
// Reset clears the counts and the sequencer; book entries are undefined.
// The receiver cannot stall: each result word shows on the ports for one cycle.
`default_nettype none
module order_book_matcher_unit
	import obm_pkg::*;
#(
	parameter int BOOK_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic        order_side,
	input  wire logic [31:0] order_price,
	input  wire logic [31:0] order_qty,
	output logic             valid,
	output logic             is_fill,
	output logic [31:0]      fill_price,
	output logic [31:0]      fill_qty,
	output logic [31:0]      unfilled_qty,
	output logic             status,
	output logic             last
);
	localparam int IW = $clog2(BOOK_DEPTH);
	localparam int CW = $clog2(BOOK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);

	// Book storage: index 0 of each side is the best order.
	logic [31:0] bp_q [BOOK_DEPTH];
	logic [31:0] bq_q [BOOK_DEPTH];
	logic [31:0] ap_q [BOOK_DEPTH];
	logic [31:0] aq_q [BOOK_DEPTH];
	logic [CW-1:0] bid_cnt_q, ask_cnt_q;

	state_t      state_q;
	logic        side_q;      // book side worked on: 1 ask book
	logic        lim_q;       // limit order, check price
	logic [31:0] price_q, qty_q;
	logic [CW-1:0] idx_q;     // scan / shift position
	logic [CW-1:0] nfill_q;   // fills emitted so far

	// Current side view
	logic [CW-1:0] cnt;
	logic [31:0]   p_at, p_prev, q_prev, p_next, q_next, p0, q0;
	logic [IW-1:0] ia, ip, inx;
	assign cnt = side_q ? ask_cnt_q : bid_cnt_q;
	assign ia  = idx_q[IW-1:0];
	assign ip  = IW'(idx_q - 1'b1);
	assign inx = IW'(idx_q + 1'b1);
	assign p_at   = side_q ? ap_q[ia] : bp_q[ia];
	assign p_prev = side_q ? ap_q[ip] : bp_q[ip];
	assign q_prev = side_q ? aq_q[ip] : bq_q[ip];
	assign p_next = side_q ? ap_q[inx] : bp_q[inx];
	assign q_next = side_q ? aq_q[inx] : bq_q[inx];
	assign p0 = side_q ? ap_q[0] : bp_q[0];
	assign q0 = side_q ? aq_q[0] : bq_q[0];

	// Shared compare / subtract unit
	logic        beyond;   // scanned entry ranks after the new order
	logic        qlt;
	logic [31:0] take, rem;
	assign beyond = side_q ? (p_at > price_q) : (p_at < price_q);
	assign qlt  = qty_q < q0;
	assign take = qlt ? qty_q : q0;
	assign rem  = q0 - take;

	logic can_take;
	assign can_take = (qty_q != 0) && (cnt != 0) && (nfill_q < DEPTH_C)
		&& !(lim_q && (p0 > price_q));

	assign busy = (state_q != ST_IDLE);

	// Insert slot: held in ins_q during the shift
	logic [CW-1:0] ins_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SHIFT: begin
				if (idx_q == ins_q) begin
					if (side_q) begin ap_q[ia] <= price_q; aq_q[ia] <= qty_q; end
					else begin bp_q[ia] <= price_q; bq_q[ia] <= qty_q; end
				end else begin
					if (side_q) begin ap_q[ia] <= p_prev; aq_q[ia] <= q_prev; end
					else begin bp_q[ia] <= p_prev; bq_q[ia] <= q_prev; end
				end
			end
			ST_TAKE: begin
				if (can_take && qlt) begin
					if (side_q) aq_q[0] <= rem;
					else bq_q[0] <= rem;
				end
			end
			ST_POP: begin
				if (side_q) begin ap_q[ia] <= p_next; aq_q[ia] <= q_next; end
				else begin bp_q[ia] <= p_next; bq_q[ia] <= q_next; end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bid_cnt_q <= '0;
			ask_cnt_q <= '0;
			valid     <= 1'b0;
			last      <= 1'b0;
			side_q    <= 1'b0;
			lim_q     <= 1'b0;
			idx_q     <= '0;
			ins_q     <= '0;
			nfill_q   <= '0;
			price_q   <= '0;
			qty_q     <= '0;
			is_fill   <= 1'b0;
			fill_price <= '0;
			fill_qty   <= '0;
			unfilled_qty <= '0;
			status    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					valid <= 1'b0;
					if (start) begin
						price_q <= order_price;
						idx_q   <= '0;
						case (action_t'(action))
							ACT_CLEAR: begin
								bid_cnt_q <= '0;
								ask_cnt_q <= '0;
								qty_q   <= '0;
								lim_q   <= 1'b0;
								nfill_q <= '0;
								state_q <= ST_TAKE;
							end
							ACT_LOAD: begin
								side_q  <= order_side;
								qty_q   <= order_qty;
								lim_q   <= 1'b0;
								nfill_q <= '0;
								// zero quantity: skip the insert, go straight to the summary
								state_q <= (order_qty == '0) ? ST_TAKE : ST_SCAN;
							end
							ACT_MARKET: begin
								side_q  <= ~order_side;
								qty_q   <= order_qty;
								lim_q   <= 1'b0;
								nfill_q <= '0;
								state_q <= ST_TAKE;
							end
							default: begin
								// limit buy checks asks; limit sell is blocked by a full fill count
								side_q  <= SIDE_SELL;
								qty_q   <= order_qty;
								lim_q   <= (order_side == SIDE_BUY);
								nfill_q <= (order_side == SIDE_SELL) ? DEPTH_C : '0;
								state_q <= ST_TAKE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (cnt >= DEPTH_C) begin
						valid <= 1'b1; last <= 1'b1; is_fill <= 1'b0;
						fill_price <= '0; fill_qty <= '0; unfilled_qty <= '0;
						status <= STATUS_FULL;
						state_q <= ST_IDLE;
					end else if (idx_q == cnt || beyond) begin
						valid <= 1'b0;
						ins_q <= idx_q;
						idx_q <= cnt;
						state_q <= ST_SHIFT;
					end else begin
						valid <= 1'b0;
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SHIFT: begin
					if (idx_q == ins_q) begin
						if (side_q) ask_cnt_q <= ask_cnt_q + 1'b1;
						else bid_cnt_q <= bid_cnt_q + 1'b1;
						valid <= 1'b1; last <= 1'b1; is_fill <= 1'b0;
						fill_price <= '0; fill_qty <= '0; unfilled_qty <= '0;
						status <= STATUS_OK;
						state_q <= ST_IDLE;
					end else begin
						valid <= 1'b0;
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_TAKE: begin
					valid <= 1'b1;
					status <= STATUS_OK;
					if (can_take) begin
						is_fill <= 1'b1; last <= 1'b0;
						fill_price <= p0; fill_qty <= take; unfilled_qty <= '0;
						qty_q <= qty_q - take;
						nfill_q <= nfill_q + 1'b1;
						if (!qlt) begin
							idx_q <= '0;
							state_q <= ST_POP;
						end
					end else begin
						is_fill <= 1'b0; last <= 1'b1;
						fill_price <= '0; fill_qty <= '0; unfilled_qty <= qty_q;
						state_q <= ST_IDLE;
					end
				end
				ST_POP: begin
					valid <= 1'b0;
					if ((idx_q + 1'b1) >= cnt) begin
						if (side_q) ask_cnt_q <= ask_cnt_q - 1'b1;
						else bid_cnt_q <= bid_cnt_q - 1'b1;
						state_q <= ST_TAKE;
					end else idx_q <= idx_q + 1'b1;
				end
				default: begin
					valid <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bid: assert property (@(posedge clk) disable iff (!arst_n) bid_cnt_q <= DEPTH_C)
		else $error("bid count beyond depth");
	a_cnt_ask: assert property (@(posedge clk) disable iff (!arst_n) ask_cnt_q <= DEPTH_C)
		else $error("ask count beyond depth");
	a_idle_nv: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> state_q == ST_IDLE)
		else $error("summary word shown while not idle");
	a_fill_nz: assert property (@(posedge clk) disable iff (!arst_n)
		valid && is_fill |-> fill_qty != 0)
		else $error("empty fill word");
`endif
endmodule
`default_nettype wire
